// ===== rtl/core/rcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types, constants and letter tables for the residue composition
// counter.
// ----------------------------------------------------------------------------
package rcc_pkg;

  localparam int COUNT_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 32;
  localparam int PROTEIN_BINS      = 21;
  localparam int DNA_BINS          = 5;
  localparam int BIN_IDX_W         = $clog2(PROTEIN_BINS);
  localparam int FRAC_FIELD_W      = 33;
  localparam int LETTER_W          = 7;
  localparam int DIVISOR_W         = 16;

  // config port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_DNA_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_DIV  = 2'd1;

  // characters
  localparam logic [7:0] CHAR_HEADER  = 8'h3E;  // '>'
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [LETTER_W-1:0] LETTER_T = 7'h54;
  localparam logic [LETTER_W-1:0] LETTER_Y = 7'h59;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0]     letter_code;
    logic [FRAC_FIELD_W-1:0] fraction;
    logic                    total_zero;
    logic                    last_bin;
  } out_item_t;

  typedef struct packed {
    logic                 hit;
    logic [BIN_IDX_W-1:0] idx;
  } bin_hit_t;

  // counter bank control
  typedef struct packed {
    logic                 inc;
    logic                 clear;
    logic [BIN_IDX_W-1:0] addr;
  } bank_ctrl_t;

  // upper-case a byte and find its bin for the current alphabet
  function automatic bin_hit_t bin_of(input logic [7:0] b, input logic dna);
    logic [7:0] up;
    bin_hit_t   r;
    up = b;
    if (b inside {[8'h61:8'h7A]}) begin
      up = b - 8'd32;
    end
    r = '{hit: 1'b1, idx: '0};
    if (dna) begin
      case (up)
        8'h41:   r.idx = 5'd0;   // A
        8'h43:   r.idx = 5'd1;   // C
        8'h47:   r.idx = 5'd2;   // G
        8'h4E:   r.idx = 5'd3;   // N
        8'h54:   r.idx = 5'd4;   // T
        default: r.hit = 1'b0;
      endcase
    end else begin
      case (up)
        8'h41:   r.idx = 5'd0;   // A
        8'h43:   r.idx = 5'd1;   // C
        8'h44:   r.idx = 5'd2;   // D
        8'h45:   r.idx = 5'd3;   // E
        8'h46:   r.idx = 5'd4;   // F
        8'h47:   r.idx = 5'd5;   // G
        8'h48:   r.idx = 5'd6;   // H
        8'h49:   r.idx = 5'd7;   // I
        8'h4B:   r.idx = 5'd8;   // K
        8'h4C:   r.idx = 5'd9;   // L
        8'h4D:   r.idx = 5'd10;  // M
        8'h4E:   r.idx = 5'd11;  // N
        8'h50:   r.idx = 5'd12;  // P
        8'h51:   r.idx = 5'd13;  // Q
        8'h52:   r.idx = 5'd14;  // R
        8'h53:   r.idx = 5'd15;  // S
        8'h54:   r.idx = 5'd16;  // T
        8'h56:   r.idx = 5'd17;  // V
        8'h57:   r.idx = 5'd18;  // W
        8'h58:   r.idx = 5'd19;  // X
        8'h59:   r.idx = 5'd20;  // Y
        default: r.hit = 1'b0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [LETTER_W-1:0] letter_of(input logic [BIN_IDX_W-1:0] idx,
                                                    input logic dna);
    logic [LETTER_W-1:0] l;
    l = 7'h41;
    if (dna) begin
      case (idx)
        5'd0:    l = 7'h41;
        5'd1:    l = 7'h43;
        5'd2:    l = 7'h47;
        5'd3:    l = 7'h4E;
        5'd4:    l = 7'h54;
        default: l = 7'h41;
      endcase
    end else begin
      case (idx)
        5'd0:    l = 7'h41;
        5'd1:    l = 7'h43;
        5'd2:    l = 7'h44;
        5'd3:    l = 7'h45;
        5'd4:    l = 7'h46;
        5'd5:    l = 7'h47;
        5'd6:    l = 7'h48;
        5'd7:    l = 7'h49;
        5'd8:    l = 7'h4B;
        5'd9:    l = 7'h4C;
        5'd10:   l = 7'h4D;
        5'd11:   l = 7'h4E;
        5'd12:   l = 7'h50;
        5'd13:   l = 7'h51;
        5'd14:   l = 7'h52;
        5'd15:   l = 7'h53;
        5'd16:   l = 7'h54;
        5'd17:   l = 7'h56;
        5'd18:   l = 7'h57;
        5'd19:   l = 7'h58;
        5'd20:   l = 7'h59;
        default: l = 7'h41;
      endcase
    end
    return l;
  endfunction

endpackage

// ===== rtl/core/rcc_alu.sv =====
// ----------------------------------------------------------------------------
// rcc_alu
// Shared add/subtract unit: accumulates the bin total, then does the trial
// subtraction of each restoring-division step.
// ----------------------------------------------------------------------------
module rcc_alu #(
  parameter int WIDTH = 38
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  rcc_pkg::alu_op_e op_i,
  output logic [WIDTH-1:0] res_o,
  output logic             carry_o   // on subtract: a >= b
);
  import rcc_pkg::*;

  logic             sub;
  logic [WIDTH-1:0] b_eff;
  logic [WIDTH:0]   sum;

  assign sub     = (op_i == ALU_SUB);
  assign b_eff   = sub ? ~b_i : b_i;
  assign sum     = {1'b0, a_i} + {1'b0, b_eff} + (WIDTH+1)'(sub);
  assign res_o   = sum[WIDTH-1:0];
  assign carry_o = sum[WIDTH];

endmodule

// ===== rtl/core/rcc_bank.sv =====
// ----------------------------------------------------------------------------
// rcc_bank
// Bin counters with one read address, a saturating increment at that
// address and a clear of all bins.
// ----------------------------------------------------------------------------
module rcc_bank #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rcc_pkg::bank_ctrl_t     ctrl_i,
  output logic [COUNT_WIDTH-1:0]  rd_data_o
);
  import rcc_pkg::*;

  logic [COUNT_WIDTH-1:0] cnt_q [PROTEIN_BINS];
  logic [COUNT_WIDTH-1:0] cur;
  logic                   addr_ok;

  assign addr_ok   = (ctrl_i.addr < BIN_IDX_W'(PROTEIN_BINS));
  assign cur       = addr_ok ? cnt_q[ctrl_i.addr] : '0;
  assign rd_data_o = cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PROTEIN_BINS; i++) cnt_q[i] <= '0;
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < PROTEIN_BINS; i++) cnt_q[i] <= '0;
    end else if (ctrl_i.inc && addr_ok && (cur != '1)) begin
      cnt_q[ctrl_i.addr] <= cur + COUNT_WIDTH'(1);
    end
  end

endmodule

// ===== rtl/core/rcc_scan.sv =====
// ----------------------------------------------------------------------------
// rcc_scan
// Line parser: header detection, line sampling phase and bin lookup for
// each text byte.
// ----------------------------------------------------------------------------
module rcc_scan (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            byte_en_i,   // byte item accepted
  input  logic [7:0]                      byte_i,
  input  logic                            clear_i,
  input  logic                            dna_mode_i,
  input  logic [rcc_pkg::DIVISOR_W-1:0]   divisor_i,
  output logic                            inc_o,
  output logic [rcc_pkg::BIN_IDX_W-1:0]   bin_idx_o
);
  import rcc_pkg::*;

  logic                 line_start_q, line_start_d;
  logic                 header_q, header_d;
  logic                 sampled_q, sampled_d;
  logic [DIVISOR_W-1:0] phase_q, phase_d;
  logic [DIVISOR_W-1:0] div_eff;
  logic [DIVISOR_W:0]   phase_inc;
  logic                 hdr_now, smp_now;
  bin_hit_t             hit;

  assign div_eff   = (divisor_i == '0) ? DIVISOR_W'(1) : divisor_i;
  assign phase_inc = {1'b0, phase_q} + (DIVISOR_W+1)'(1);
  assign hit       = bin_of(byte_i, dna_mode_i);

  always_comb begin
    hdr_now = header_q;
    smp_now = sampled_q;
    phase_d = phase_q;
    if (line_start_q) begin
      if (byte_i == CHAR_HEADER) begin
        hdr_now = 1'b1;
        smp_now = 1'b0;
      end else begin
        hdr_now = 1'b0;
        if (phase_inc >= {1'b0, div_eff}) begin
          smp_now = 1'b1;
          phase_d = '0;
        end else begin
          smp_now = 1'b0;
          phase_d = phase_inc[DIVISOR_W-1:0];
        end
      end
    end
    line_start_d = 1'b0;
    header_d     = hdr_now;
    sampled_d    = smp_now;
    if (byte_i == CHAR_NEWLINE) begin
      line_start_d = 1'b1;
      header_d     = 1'b0;
      sampled_d    = 1'b0;
    end
  end

  assign inc_o     = byte_en_i && !hdr_now && smp_now && hit.hit;
  assign bin_idx_o = hit.idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_start_q <= 1'b1;
      header_q     <= 1'b0;
      sampled_q    <= 1'b0;
      phase_q      <= '0;
    end else if (clear_i) begin
      line_start_q <= 1'b1;
      header_q     <= 1'b0;
      sampled_q    <= 1'b0;
      phase_q      <= '0;
    end else if (byte_en_i) begin
      line_start_q <= line_start_d;
      header_q     <= header_d;
      sampled_q    <= sampled_d;
      phase_q      <= phase_d;
    end
  end

endmodule

// ===== rtl/core/residue_composition_counter_top.sv =====
// ----------------------------------------------------------------------------
// residue_composition_counter_top
// Residue letter histogram over a FASTA byte stream, with a fixed-point
// composition report on the end-of-file item.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  in        sink       in_valid_i/in_stall_o   in_item_i  (text_byte, end_of_file)
//  out       source     out_valid_o/out_stall_i out_item_o (letter, fraction, flags)
//  cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  Text bytes can arrive back to back while no report is running.
//  An end-of-file item starts the report: the n bins are summed on the
//  shared adder, then each bin is loaded, divided in FRACTION_BITS steps on
//  that same adder and its result item held until taken, which output
//  stalls can delay. in_stall_o is high until the last bin item is taken.
//  Reset is asynchronous, active low; counters and line state clear at once,
//  and again in the cycle the last bin item leaves.
//  cfg_ready_o is always high; write registers only while idle.
//
module residue_composition_counter_top #(
  parameter int COUNT_WIDTH   = rcc_pkg::COUNT_WIDTH_DEF,
  parameter int FRACTION_BITS = rcc_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  rcc_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rcc_pkg::out_item_t               out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rcc_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [rcc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import rcc_pkg::*;

  localparam int TW     = COUNT_WIDTH + 5;          // total of up to 21 bins
  localparam int AW     = TW + 1;                   // adder width
  localparam int SW     = $clog2(FRACTION_BITS);
  localparam int WIDE_W = (FRACTION_BITS + 1 > FRAC_FIELD_W) ?
                          FRACTION_BITS + 1 : FRAC_FIELD_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [BIN_IDX_W-1:0]     idx_q, idx_d;
  logic [BIN_IDX_W-1:0]     last_idx;
  logic [TW-1:0]            total_q, total_d;
  logic [TW-1:0]            rem_q, rem_d;
  logic [FRACTION_BITS-1:0] quo_q, quo_d;
  logic                     full_q, full_d;
  logic [SW-1:0]            step_q, step_d;
  out_item_t                out_q, out_d;
  logic                     dna_mode_q;
  logic [DIVISOR_W-1:0]     divisor_q;

  logic                     in_acc, byte_en, eof_acc, out_acc, report_done;
  logic                     scan_inc;
  logic [BIN_IDX_W-1:0]     scan_idx;
  bank_ctrl_t               bank_ctrl;
  logic [COUNT_WIDTH-1:0]   cnt_rd;

  logic [AW-1:0]            alu_a, alu_b, alu_res;
  alu_op_e                  alu_op;
  logic                     alu_carry;
  logic [FRACTION_BITS-1:0] quo_next;
  logic [WIDE_W-1:0]        frac_wide;

  // handshakes
  assign in_acc      = in_valid_i && !in_stall_o;
  assign byte_en     = in_acc && !in_item_i.end_of_file;
  assign eof_acc     = in_acc && in_item_i.end_of_file;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign report_done = out_acc && out_q.last_bin;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign last_idx = dna_mode_q ? BIN_IDX_W'(DNA_BINS - 1) : BIN_IDX_W'(PROTEIN_BINS - 1);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dna_mode_q <= 1'b0;
      divisor_q  <= DIVISOR_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DNA_MODE:   dna_mode_q <= cfg_data_i[0];
        REG_SAMPLE_DIV: divisor_q  <= cfg_data_i[DIVISOR_W-1:0];
        default:        ;
      endcase
    end
  end

  rcc_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_en_i  (byte_en),
    .byte_i     (in_item_i.text_byte),
    .clear_i    (report_done),
    .dna_mode_i (dna_mode_q),
    .divisor_i  (divisor_q),
    .inc_o      (scan_inc),
    .bin_idx_o  (scan_idx)
  );

  // bank address follows the scanner while idle, the sequencer otherwise
  assign bank_ctrl.inc   = scan_inc;
  assign bank_ctrl.clear = report_done;
  assign bank_ctrl.addr  = (state_q == ST_IDLE) ? scan_idx : idx_q;

  rcc_bank #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (bank_ctrl),
    .rd_data_o (cnt_rd)
  );

  // shared adder: accumulate in SUM, trial subtract in DIV
  always_comb begin
    if (state_q == ST_DIV) begin
      alu_op = ALU_SUB;
      alu_a  = {rem_q, 1'b0};
      alu_b  = {1'b0, total_q};
    end else begin
      alu_op = ALU_ADD;
      alu_a  = {1'b0, total_q};
      alu_b  = AW'(cnt_rd);
    end
  end

  rcc_alu #(
    .WIDTH (AW)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .op_i    (alu_op),
    .res_o   (alu_res),
    .carry_o (alu_carry)
  );

  assign quo_next = {quo_q[FRACTION_BITS-2:0], alu_carry};
  // a bin holding the whole total reads exactly one
  assign frac_wide = full_q ? (WIDE_W'(1) << FRACTION_BITS) : WIDE_W'(quo_next);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    total_d = total_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    full_d  = full_q;
    step_d  = step_q;
    out_d   = out_q;
    case (state_q)
      ST_IDLE: begin
        if (eof_acc) begin
          idx_d   = '0;
          total_d = '0;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        total_d = alu_res[TW-1:0];
        if (idx_q == last_idx) begin
          idx_d   = '0;
          state_d = ST_LOAD;
        end else begin
          idx_d = idx_q + BIN_IDX_W'(1);
        end
      end
      ST_LOAD: begin
        rem_d   = TW'(cnt_rd);
        full_d  = (TW'(cnt_rd) == total_q);
        quo_d   = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // restoring step: keep the difference when the trial fits
        rem_d  = alu_carry ? alu_res[TW-1:0] : alu_a[TW-1:0];
        quo_d  = quo_next;
        step_d = step_q + SW'(1);
        if (step_q == SW'(FRACTION_BITS - 1)) begin
          out_d.letter_code = letter_of(idx_q, dna_mode_q);
          out_d.total_zero  = (total_q == '0);
          out_d.fraction    = (total_q == '0) ? '0 : frac_wide[FRAC_FIELD_W-1:0];
          out_d.last_bin    = (idx_q == last_idx);
          state_d           = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          if (out_q.last_bin) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + BIN_IDX_W'(1);
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    full_q  <= full_d;
    out_q   <= out_d;
  end

  // checks
  a_zero_total_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.total_zero |-> out_item_o.fraction == '0)
    else $error("fraction nonzero on a zero total");

  a_last_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last_bin |->
      (dna_mode_q && out_item_o.letter_code == LETTER_T) ||
      (!dna_mode_q && out_item_o.letter_code == LETTER_Y))
    else $error("last bin flag on wrong letter");

  a_report_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_item_o.last_bin |=> state_q == ST_IDLE && !out_valid_o)
    else $error("report did not return to idle");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> step_q <= SW'(FRACTION_BITS - 1))
    else $error("divide step counter overran");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> idx_q <= last_idx)
    else $error("bin index beyond the alphabet");

endmodule

// ===== tb/sv/composition_checker.sv =====
// ----------------------------------------------------------------------------
// composition_checker
// Watches the byte, report and register channels of the residue composition
// counter, keeps its own copy of the bin tallies and line state, and checks
// every report item against the predicted letter, fraction and flags.
// ----------------------------------------------------------------------------
module composition_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  rcc_pkg::in_item_t               in_item_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  rcc_pkg::out_item_t              out_item_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [rcc_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [rcc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                              pending_o,
  output int                              mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import rcc_pkg::*;

  localparam int CW = COUNT_WIDTH_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam logic [8*PROTEIN_BINS-1:0] PROTEIN_CHARS = "ACDEFGHIKLMNPQRSTVWXY";
  localparam logic [8*DNA_BINS-1:0]     NUC_CHARS     = "ACGNT";

  logic [CW-1:0]        tally [PROTEIN_BINS];
  logic                 line_start;
  logic                 header_line;
  logic                 line_counted;
  logic [DIVISOR_W-1:0] line_phase;
  logic                 nuc_mode;
  logic [DIVISOR_W-1:0] divisor;
  out_item_t            report_q [$];
  int                   mismatches;

  function automatic logic [7:0] bin_char(input int i, input logic dna);
    if (dna) return NUC_CHARS[8*(DNA_BINS-1-i) +: 8];
    return PROTEIN_CHARS[8*(PROTEIN_BINS-1-i) +: 8];
  endfunction

  // -1 when the byte is no letter of the current alphabet
  function automatic int bin_index(input logic [7:0] b, input logic dna);
    logic [7:0] up;
    int         n;
    up = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
    n  = dna ? DNA_BINS : PROTEIN_BINS;
    for (int i = 0; i < n; i++) begin
      if (bin_char(i, dna) == up) return i;
    end
    return -1;
  endfunction

  task automatic clear_stream();
    for (int i = 0; i < PROTEIN_BINS; i++) tally[i] = '0;
    line_start   = 1'b1;
    header_line  = 1'b0;
    line_counted = 1'b0;
    line_phase   = '0;
  endtask

  task automatic tally_byte(input logic [7:0] b);
    logic [DIVISOR_W-1:0] eff_div;
    int                   idx;
    if (line_start) begin
      line_start = 1'b0;
      if (b == CHAR_HEADER) begin
        header_line  = 1'b1;
        line_counted = 1'b0;
      end else begin
        eff_div     = (divisor == '0) ? DIVISOR_W'(1) : divisor;
        header_line = 1'b0;
        if ({1'b0, line_phase} + 17'd1 >= {1'b0, eff_div}) begin
          line_counted = 1'b1;
          line_phase   = '0;
        end else begin
          line_counted = 1'b0;
          line_phase   = line_phase + DIVISOR_W'(1);
        end
      end
    end
    if (!header_line && line_counted) begin
      idx = bin_index(b, nuc_mode);
      if (idx >= 0 && tally[idx] != '1) tally[idx] = tally[idx] + CW'(1);
    end
    if (b == CHAR_NEWLINE) begin
      line_start   = 1'b1;
      header_line  = 1'b0;
      line_counted = 1'b0;
    end
  endtask

  task automatic queue_report();
    int               n;
    logic [CW+5:0]    total;
    logic [CW+FB-1:0] scaled;
    logic [7:0]       ch;
    out_item_t        r;
    n     = nuc_mode ? DNA_BINS : PROTEIN_BINS;
    total = '0;
    for (int i = 0; i < n; i++) total = total + (CW+6)'(tally[i]);
    for (int i = 0; i < n; i++) begin
      ch            = bin_char(i, nuc_mode);
      r.letter_code = ch[LETTER_W-1:0];
      if (total == '0) begin
        r.fraction   = '0;
        r.total_zero = 1'b1;
      end else begin
        scaled       = {tally[i], {FB{1'b0}}} / total;
        r.fraction   = scaled[FRAC_FIELD_W-1:0];
        r.total_zero = 1'b0;
      end
      r.last_bin = (i == n - 1);
      report_q.push_back(r);
    end
    clear_stream();
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (report_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t composition_checker: unexpected item letter %0h frac %0h zero %0b last %0b",
                 $realtime, got.letter_code, got.fraction, got.total_zero, got.last_bin);
      return;
    end
    want = report_q.pop_front();
    if (got.letter_code !== want.letter_code || got.fraction !== want.fraction ||
        got.total_zero !== want.total_zero || got.last_bin !== want.last_bin) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t composition_checker: mismatch exp letter %0h frac %0h zero %0b last %0b",
                  " / got letter %0h frac %0h zero %0b last %0b"}, $realtime,
                 want.letter_code, want.fraction, want.total_zero, want.last_bin,
                 got.letter_code, got.fraction, got.total_zero, got.last_bin);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_stream();
      nuc_mode = 1'b0;
      divisor  = DIVISOR_W'(1);
      report_q.delete();
      mismatches = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_DNA_MODE) nuc_mode = cfg_data_i[0];
        else if (cfg_index_i == REG_SAMPLE_DIV) divisor = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_item_i.end_of_file) queue_report();
        else tally_byte(in_item_i.text_byte);
      end
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      pending_o    <= report_q.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the residue composition counter: a directed FASTA sequence
// covering headers, blank lines, case folding, sampling and mode changes,
// then random FASTA records under four idle/stall patterns. Checking is done
// by composition_checker; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcc_pkg::*;

  localparam logic [8*DNA_BINS-1:0] NUC_CHARS = "ACGNT";

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_valid_q  = 1'b0;
  in_item_t               in_item_q   = '0;
  logic                   out_stall_q = 1'b0;
  logic                   cfg_valid_q = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_q = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_q  = '0;

  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;
  logic      cfg_ready_o;

  int pending_count;
  int mismatch_count;

  // percent of cycles the byte sender idles / the report receiver stalls
  int idle_pct  = 0;
  int stall_pct = 0;
  int items_sent = 0;

  always #5 clk = ~clk;

  residue_composition_counter_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid_q),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_q),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_q),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_q),
    .cfg_data_i  (cfg_data_q)
  );

  composition_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid_q),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_q),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_q),
    .out_item_i   (out_item_o),
    .cfg_valid_i  (cfg_valid_q),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_q),
    .cfg_data_i   (cfg_data_q),
    .pending_o    (pending_count),
    .mismatches_o (mismatch_count)
  );

  // Receiver back-pressure: independent of out_valid, redrawn every cycle.
  always @(posedge clk) begin
    out_stall_q <= ($urandom_range(99) < stall_pct);
  end

  // Offer one item, after a random idle gap, and hold it until taken.
  // valid stays high into the next item when there is no gap.
  task automatic push_item(input logic [7:0] b, input logic eof);
    int       gap;
    in_item_t it;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_q <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.text_byte   = b;
    it.end_of_file = eof;
    in_valid_q <= 1'b1;
    in_item_q  <= it;
    do @(posedge clk); while (in_stall_o);
    items_sent++;
  endtask

  // Stop sending and wait until every predicted report item has come out.
  // pending_count is registered, so the first edge is skipped unconditionally.
  // The trailing wait covers the byte path and the post-report clear.
  task automatic drain_reports();
    in_valid_q <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both registers, back to back; only called with the block idle.
  task automatic write_config(input logic dna, input logic [CFG_DATA_W-1:0] div);
    cfg_valid_q <= 1'b1;
    cfg_index_q <= REG_DNA_MODE;
    cfg_data_q  <= {{(CFG_DATA_W-1){1'b0}}, dna};
    do @(posedge clk); while (!cfg_ready_o);
    cfg_index_q <= REG_SAMPLE_DIV;
    cfg_data_q  <= div;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid_q <= 1'b0;
  endtask

  // Sequence byte: mostly letters (nucleotides favored in DNA mode), random
  // case, with 1 in 8 arbitrary bytes as noise (may hit newline or '>').
  function automatic logic [7:0] residue_byte(input logic dna);
    logic [7:0] c;
    int         k;
    if ($urandom_range(7) == 0) return 8'($urandom_range(255));
    if (dna && $urandom_range(3) != 0) begin
      k = $urandom_range(DNA_BINS - 1);
      c = NUC_CHARS[8*k +: 8];
    end else begin
      c = 8'h41 + 8'($urandom_range(25));
    end
    if ($urandom_range(1) == 1) c = c | 8'h20;
    return c;
  endfunction

  // One random FASTA record: optional header, 1-3 sequence lines, end marker.
  task automatic send_record(input logic dna);
    int lines;
    int len;
    if ($urandom_range(1) == 1) begin
      push_item(CHAR_HEADER, 1'b0);
      repeat ($urandom_range(5)) push_item(8'($urandom_range(255)), 1'b0);
      push_item(CHAR_NEWLINE, 1'b0);
    end
    lines = $urandom_range(1, 3);
    for (int l = 0; l < lines; l++) begin
      len = $urandom_range(8);
      repeat (len) push_item(residue_byte(dna), 1'b0);
      // last line sometimes runs straight into the end marker
      if (l < lines - 1 || $urandom_range(3) != 0) push_item(CHAR_NEWLINE, 1'b0);
    end
    push_item(8'($urandom_range(255)), 1'b1);
    // now and then let the whole report drain before the next record
    if ($urandom_range(3) == 0) drain_reports();
  endtask

  initial begin
    int   target;
    logic nuc;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    // empty stream: zero total, every fraction zero
    write_config(1'b0, 16'd1);
    push_item(8'h00, 1'b1);
    drain_reports();

    // header skipped (its letter too), lower case folded, 0xFF/0x00 ignored,
    // blank line, final line without newline
    push_item(CHAR_HEADER, 1'b0);
    push_item("Q", 1'b0);
    push_item(CHAR_NEWLINE, 1'b0);
    push_item("a", 1'b0);
    push_item("Y", 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(CHAR_NEWLINE, 1'b0);
    push_item(CHAR_NEWLINE, 1'b0);
    push_item("W", 1'b0);
    push_item(8'hFF, 1'b1);
    drain_reports();

    // DNA mode with a zero divisor (acts as 1); '>' mid-line is just noise
    write_config(1'b1, 16'd0);
    push_item("g", 1'b0);
    push_item("N", 1'b0);
    push_item("T", 1'b0);
    push_item(CHAR_HEADER, 1'b0);
    push_item("E", 1'b0);
    push_item(CHAR_NEWLINE, 1'b1);
    drain_reports();

    // largest divisor skips the line; lowering it mid-stream makes the next
    // line count at once; switch to protein before the report
    write_config(1'b1, 16'hFFFF);
    push_item("A", 1'b0);
    push_item(CHAR_NEWLINE, 1'b0);
    drain_reports();
    write_config(1'b1, 16'd1);
    push_item("C", 1'b0);
    drain_reports();
    write_config(1'b0, 16'd1);
    push_item("d", 1'b0);
    push_item(8'h80, 1'b1);
    drain_reports();

    // ---- random records, one idle pattern per phase ----
    for (int ph = 0; ph < 4; ph++) begin
      drain_reports();
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct <= 0;
          nuc = 1'b0;
          write_config(nuc, 16'd1);
        end
        1: begin
          idle_pct  = 82;
          stall_pct <= 0;
          nuc = 1'b1;
          write_config(nuc, 16'd2);
        end
        2: begin
          idle_pct  = 0;
          stall_pct <= 82;
          nuc = 1'b0;
          write_config(nuc, 16'($urandom_range(1, 3)));
        end
        default: begin
          idle_pct  = 25;
          stall_pct <= 25;
          nuc = 1'b1;
          write_config(nuc, 16'd1);
        end
      endcase
      target = items_sent + 85;
      while (items_sent < target) send_record(nuc);
    end

    drain_reports();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog. Worst case: all ~370 items are end markers, each a 21-bin
  // report under 82% receiver stall; 20 ms is over six times that run.
  initial begin
    #20_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rcc_pkg.sv
rtl/core/rcc_alu.sv
rtl/core/rcc_bank.sv
rtl/core/rcc_scan.sv
rtl/core/residue_composition_counter_top.sv
tb/sv/composition_checker.sv
tb/sv/tb_top.sv
